// ===== src/scale2x_pixel_upscaler_assert.svh =====
// Assertion helpers for the upscaler checker.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef SCALE2X_PIXEL_UPSCALER_ASSERT_SVH
`define SCALE2X_PIXEL_UPSCALER_ASSERT_SVH

// Same-cycle implication
`define SCL2X_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scale2x port check failed");

// Next-cycle implication
`define SCL2X_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scale2x port check failed");

`endif

// ===== src/scl2x_pkg.sv =====
`default_nettype none

package scl2x_pkg;

    // Frame limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int CFG_W = 11;
    localparam int PIX_W = 32;

    // Register reset values
    localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(320);
    localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(224);

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
    localparam int PUSH_MAX   = 3;

    typedef struct packed {
        logic [PIX_W-1:0] e0;
        logic [PIX_W-1:0] e1;
        logic [PIX_W-1:0] e2;
        logic [PIX_W-1:0] e3;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             done;
    } block_t;

    // Up to three blocks per item, in raster order: above, trailing, last
    typedef struct packed {
        logic   [PUSH_MAX-1:0] valid;
        block_t [PUSH_MAX-1:0] blk;
    } push_t;

endpackage

`default_nettype wire

// ===== src/scale2x_pixel_upscaler.sv =====
// A block is offered from the result queue: the pixel that completes it is first
// registered in the working stage, which then writes the block into the queue.
// Throughput: one pixel per cycle while pixel_stall is low, on all rows but the last;
// on the last row most pixels yield two blocks for the single output channel.
// The line stores are read in the acceptance cycle and written in the cycle after.
// Reset clears the counters, the result queue and the registers to 320 x 224;
// the line stores are not cleared.
`default_nettype none

module scale2x_pixel_upscaler (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [scl2x_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [scl2x_pkg::APB_DATA_W-1:0] pwdata,
    output logic [scl2x_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    input  logic                             pixel_valid,
    output logic                             pixel_stall,
    input  logic [scl2x_pkg::PIX_W-1:0]      pixel_in,
    output logic                             block_valid,
    input  logic                             block_stall,
    output logic [scl2x_pkg::PIX_W-1:0]      top_left,
    output logic [scl2x_pkg::PIX_W-1:0]      top_right,
    output logic [scl2x_pkg::PIX_W-1:0]      bottom_left,
    output logic [scl2x_pkg::PIX_W-1:0]      bottom_right,
    output logic [scl2x_pkg::ROW_W-1:0]      block_row,
    output logic [scl2x_pkg::COL_W-1:0]      block_col,
    output logic                             frame_done
);

    import scl2x_pkg::*;

    typedef struct packed {
        logic above;
        logic b_ok;
        logic d_ok;
        logic d2_ok;
        logic f_ok;
        logic trail;
        logic last;
    } stage_flags_t;

    localparam int SUM_W = FIFO_CNT_W + 1;

    // Configuration
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             cfg_write;
    reg_idx_t         reg_sel;
    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;

    // Position counters
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;
    logic             restart;
    logic [COL_W-1:0] cur_col;
    logic [ROW_W-1:0] cur_row;
    logic [CFG_W-1:0] col_inc;
    logic [CFG_W-1:0] row_inc;
    logic             row_end;
    logic             frame_end;
    logic             last_row;
    logic             pixel_accept;
    logic [COL_W-1:0] mid_f_addr;
    stage_flags_t     flags_next;

    // Working stage
    logic             s1_valid_reg;
    stage_flags_t     s1_flags_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_fwd_e_reg;
    logic             s1_fwd_f_reg;
    logic [PIX_W-1:0] s1_fwd_pix_reg;
    logic [PIX_W-1:0] s1_fwd_up_reg;
    logic [PIX_W-1:0] rec0_reg;
    logic [PIX_W-1:0] rec1_reg;
    logic [PIX_W-1:0] prev_mid_reg;

    logic [PIX_W-1:0] mid_e_rdata;
    logic [PIX_W-1:0] mid_f_rdata;
    logic [PIX_W-1:0] up_rdata;
    logic [PIX_W-1:0] mid_e;
    logic [PIX_W-1:0] mid_f;
    logic [PIX_W-1:0] up_b;

    logic [PIX_W-1:0] ab_b;
    logic [PIX_W-1:0] ab_d;
    logic [PIX_W-1:0] ab_f;
    logic [PIX_W-1:0] tr_b;
    logic [PIX_W-1:0] tr_d;
    logic [PIX_W-1:0] ls_b;
    logic [PIX_W-1:0] ls_d;

    block_t                above_blk;
    block_t                trail_blk;
    block_t                last_blk;
    push_t                 push;
    block_t                head;
    logic [FIFO_CNT_W-1:0] fifo_count;
    logic [SUM_W-1:0]      pending;

    // Register write decode
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = reg_idx_t'(paddr[2]);
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_WIDTH;
            height_reg <= RESET_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_FRAME_WIDTH:  width_reg  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= pwdata[CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    // Register read-back, zero off the word grid
    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            unique case (reg_sel)
                REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_reg);
                REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_reg);
                default:          prdata = '0;
            endcase
        end
    end

    // Clamp the frame size into range
    assign w_eff = (width_reg == '0) ? CFG_W'(1) :
                   (width_reg > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg == '0) ? CFG_W'(1) :
                   (height_reg > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : height_reg;

    // Position of the incoming item; restart the frame if out of range
    assign restart   = (CFG_W'(col_reg) >= w_eff) || (CFG_W'(row_reg) >= h_eff);
    assign cur_col   = restart ? '0 : col_reg;
    assign cur_row   = restart ? '0 : row_reg;
    assign col_inc   = CFG_W'(cur_col) + CFG_W'(1);
    assign row_inc   = CFG_W'(cur_row) + CFG_W'(1);
    assign row_end   = (col_inc >= w_eff);
    assign frame_end = (row_inc >= h_eff);
    assign last_row  = (row_inc == h_eff);
    assign mid_f_addr = cur_col + COL_W'(1);

    assign col_next = row_end ? '0 : col_inc[COL_W-1:0];
    assign row_next = row_end ? (frame_end ? '0 : row_inc[ROW_W-1:0]) : cur_row;

    // Neighbour validity and which blocks the item will release
    always_comb
    begin
        flags_next.above = (cur_row != '0);
        flags_next.b_ok  = (cur_row > ROW_W'(1));
        flags_next.d_ok  = (cur_col != '0);
        flags_next.d2_ok = (cur_col > COL_W'(1));
        flags_next.f_ok  = (col_inc < w_eff);
        flags_next.trail = last_row && (cur_col != '0);
        flags_next.last  = last_row && row_end;
    end

    // Hold new items while the result queue may lack room
    assign pending     = SUM_W'(push.valid[0]) + SUM_W'(push.valid[1]) +
                         SUM_W'(push.valid[2]);
    assign pixel_stall = (SUM_W'(fifo_count) + pending + SUM_W'(PUSH_MAX)) >
                         SUM_W'(FIFO_DEPTH);
    assign pixel_accept = pixel_valid && !pixel_stall;

    // Counters and stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pixel_accept;
            if (pixel_accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // Capture the item and note reads that collide with this cycle's write
    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            s1_flags_reg   <= flags_next;
            s1_pixel_reg   <= pixel_in;
            s1_row_reg     <= cur_row;
            s1_col_reg     <= cur_col;
            s1_fwd_e_reg   <= s1_valid_reg && (s1_col_reg == cur_col);
            s1_fwd_f_reg   <= s1_valid_reg && (s1_col_reg == mid_f_addr);
            s1_fwd_pix_reg <= s1_pixel_reg;
            s1_fwd_up_reg  <= mid_e;
        end
    end

    // Line stores: middle row twice for two read addresses, upper row once
    scl2x_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_e_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_pixel_reg),
        .raddr (cur_col),
        .rdata (mid_e_rdata)
    );

    scl2x_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_mid_f_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (s1_pixel_reg),
        .raddr (mid_f_addr),
        .rdata (mid_f_rdata)
    );

    scl2x_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_up_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (mid_e),
        .raddr (cur_col),
        .rdata (up_rdata)
    );

    // Forward the previous item's writes over stale read data
    assign mid_e = s1_fwd_e_reg ? s1_fwd_pix_reg : mid_e_rdata;
    assign mid_f = s1_fwd_f_reg ? s1_fwd_pix_reg : mid_f_rdata;
    assign up_b  = s1_fwd_e_reg ? s1_fwd_up_reg  : up_rdata;

    // Shift the row history
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            rec1_reg     <= rec0_reg;
            rec0_reg     <= s1_pixel_reg;
            prev_mid_reg <= mid_e;
        end
    end

    // Block of the row above, completed by this item
    assign ab_b = s1_flags_reg.b_ok ? up_b : mid_e;
    assign ab_d = s1_flags_reg.d_ok ? prev_mid_reg : mid_e;
    assign ab_f = s1_flags_reg.f_ok ? mid_f : mid_e;

    scl2x_kernel u_above (
        .b  (ab_b),
        .d  (ab_d),
        .e  (mid_e),
        .f  (ab_f),
        .h  (s1_pixel_reg),
        .e0 (above_blk.e0),
        .e1 (above_blk.e1),
        .e2 (above_blk.e2),
        .e3 (above_blk.e3)
    );

    assign above_blk.row  = s1_row_reg - ROW_W'(1);
    assign above_blk.col  = s1_col_reg;
    assign above_blk.done = 1'b0;

    // Last row: block one column behind
    assign tr_b = s1_flags_reg.above ? prev_mid_reg : rec0_reg;
    assign tr_d = s1_flags_reg.d2_ok ? rec1_reg : rec0_reg;

    scl2x_kernel u_trail (
        .b  (tr_b),
        .d  (tr_d),
        .e  (rec0_reg),
        .f  (s1_pixel_reg),
        .h  (rec0_reg),
        .e0 (trail_blk.e0),
        .e1 (trail_blk.e1),
        .e2 (trail_blk.e2),
        .e3 (trail_blk.e3)
    );

    assign trail_blk.row  = s1_row_reg;
    assign trail_blk.col  = s1_col_reg - COL_W'(1);
    assign trail_blk.done = 1'b0;

    // Final pixel flushes its own block
    assign ls_b = s1_flags_reg.above ? mid_e : s1_pixel_reg;
    assign ls_d = s1_flags_reg.d_ok ? rec0_reg : s1_pixel_reg;

    scl2x_kernel u_last (
        .b  (ls_b),
        .d  (ls_d),
        .e  (s1_pixel_reg),
        .f  (s1_pixel_reg),
        .h  (s1_pixel_reg),
        .e0 (last_blk.e0),
        .e1 (last_blk.e1),
        .e2 (last_blk.e2),
        .e3 (last_blk.e3)
    );

    assign last_blk.row  = s1_row_reg;
    assign last_blk.col  = s1_col_reg;
    assign last_blk.done = 1'b1;

    // Queue the released blocks in raster order
    assign push.valid = s1_valid_reg ?
                        {s1_flags_reg.last, s1_flags_reg.trail, s1_flags_reg.above} : '0;
    assign push.blk   = {last_blk, trail_blk, above_blk};

    scl2x_result_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (block_valid && !block_stall),
        .head  (head),
        .count (fifo_count)
    );

    // Result channel
    assign block_valid  = (fifo_count != '0);
    assign top_left     = head.e0;
    assign top_right    = head.e1;
    assign bottom_left  = head.e2;
    assign bottom_right = head.e3;
    assign block_row    = head.row;
    assign block_col    = head.col;
    assign frame_done   = head.done;

endmodule

`default_nettype wire

// ===== src/scl2x_ram.sv =====
`default_nettype none

module scl2x_ram #(
    parameter int  WIDTH  = 32,
    parameter int  DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, registered read port returning old data on a collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/scl2x_kernel.sv =====
`default_nettype none

module scl2x_kernel (
    input  logic [scl2x_pkg::PIX_W-1:0] b,
    input  logic [scl2x_pkg::PIX_W-1:0] d,
    input  logic [scl2x_pkg::PIX_W-1:0] e,
    input  logic [scl2x_pkg::PIX_W-1:0] f,
    input  logic [scl2x_pkg::PIX_W-1:0] h,
    output logic [scl2x_pkg::PIX_W-1:0] e0,
    output logic [scl2x_pkg::PIX_W-1:0] e1,
    output logic [scl2x_pkg::PIX_W-1:0] e2,
    output logic [scl2x_pkg::PIX_W-1:0] e3
);

    import scl2x_pkg::*;

    logic db_eq;
    logic bf_eq;
    logic dh_eq;
    logic hf_eq;

    // Shared neighbour equalities
    assign db_eq = (d == b);
    assign bf_eq = (b == f);
    assign dh_eq = (d == h);
    assign hf_eq = (h == f);

    // Pick each quadrant from its corner neighbour or the centre
    assign e0 = (db_eq && !bf_eq && !dh_eq) ? d : e;
    assign e1 = (bf_eq && !db_eq && !hf_eq) ? f : e;
    assign e2 = (dh_eq && !db_eq && !hf_eq) ? d : e;
    assign e3 = (hf_eq && !dh_eq && !bf_eq) ? f : e;

endmodule

`default_nettype wire

// ===== src/scl2x_result_fifo.sv =====
`default_nettype none

module scl2x_result_fifo (
    input  logic                             clk,
    input  logic                             rst_n,
    input  scl2x_pkg::push_t                 push,
    input  logic                             pop,
    output scl2x_pkg::block_t                head,
    output logic [scl2x_pkg::FIFO_CNT_W-1:0] count
);

    import scl2x_pkg::*;

    block_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_PTR_W-1:0] offset [PUSH_MAX];
    logic [FIFO_CNT_W-1:0] push_count;

    // Pack the pushed blocks into consecutive slots
    always_comb
    begin
        push_count = '0;
        for (int k = 0; k < PUSH_MAX; k++)
        begin
            offset[k]  = push_count[FIFO_PTR_W-1:0];
            push_count = push_count + FIFO_CNT_W'(push.valid[k]);
        end
    end

    // Store pushed blocks
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < PUSH_MAX; k++)
        begin
            if (push.valid[k])
            begin
                mem[wr_ptr_reg + offset[k]] <= push.blk[k];
            end
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + push_count[FIFO_PTR_W-1:0];
            rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(pop);
            count_reg  <= count_reg + push_count - FIFO_CNT_W'(pop);
        end
    end

    assign head  = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

`default_nettype wire

// ===== src/scl2x_checker.sv =====
`default_nettype none

`include "scale2x_pixel_upscaler_assert.svh"

module scl2x_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        pixel_valid,
    input logic                        pixel_stall,
    input logic                        block_valid,
    input logic                        block_stall,
    input logic [scl2x_pkg::PIX_W-1:0] top_left,
    input logic [scl2x_pkg::PIX_W-1:0] top_right,
    input logic [scl2x_pkg::PIX_W-1:0] bottom_left,
    input logic [scl2x_pkg::PIX_W-1:0] bottom_right,
    input logic [scl2x_pkg::ROW_W-1:0] block_row,
    input logic [scl2x_pkg::COL_W-1:0] block_col,
    input logic                        frame_done
);

    logic [4*scl2x_pkg::PIX_W+scl2x_pkg::ROW_W+scl2x_pkg::COL_W:0] block_payload;

    // Gather the whole result item
    assign block_payload = {top_left, top_right, bottom_left, bottom_right,
                            block_row, block_col, frame_done};

    // A stalled result stays offered
    `SCL2X_ASSERT_NEXT(block_hold_chk, block_valid && block_stall, block_valid)

    // A stalled result keeps its payload
    `SCL2X_ASSERT_NEXT(block_payload_chk, block_valid && block_stall, $stable(block_payload))

    // Input is only held back while results wait to drain
    `SCL2X_ASSERT_IMPLY(stall_backlog_chk, pixel_stall, block_valid)

    // Results appear only after a taken pixel has passed the working stage and the queue
    `SCL2X_ASSERT_IMPLY(result_source_chk, $rose(block_valid), $past(pixel_valid && !pixel_stall, 2))

endmodule

bind scale2x_pixel_upscaler scl2x_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .block_valid  (block_valid),
    .block_stall  (block_stall),
    .top_left     (top_left),
    .top_right    (top_right),
    .bottom_left  (bottom_left),
    .bottom_right (bottom_right),
    .block_row    (block_row),
    .block_col    (block_col),
    .frame_done   (frame_done)
);

`default_nettype wire
